>>> sv/pmnc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the palette merge block.
package pmnc_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int MEMO_DEPTH_DEF    = 512;

  localparam int CMD_W   = 3;
  localparam int COLOR_W = 32;
  localparam int IDX_W   = 8;
  localparam int KIND_W  = 2;
  localparam int PSIZE_W = 9;
  localparam int THR_W   = 10;
  localparam int KEY_W   = 24;
  localparam int SUM_W   = 10;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEWSRC = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MAP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_MEMO    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXACT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEAREST = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

  localparam logic [THR_W-1:0] THR_RESET = 10'd36;
  localparam logic [SUM_W-1:0] NO_DIFF   = 10'd768;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MSCAN,
    S_PSCAN,
    S_MINS_KEY,
    S_MSCAN2,
    S_MINS_CHK,
    S_RDWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic in_load;
    logic clear_all;
    logic clear_memo;
    logic do_append;
    logic mscan_start;
    logic mscan_run;
    logic key_sel_best;
    logic pscan_start;
    logic pscan_run;
    logic set_memo_hit;
    logic set_exact;
    logic set_nearest;
    logic memo_ins;
    logic rd_issue;
    logic rd_capture;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             pal_full;
    logic             rd_in_range;
    logic             ms_hit;
    logic             ms_end;
    logic             ps_exact;
    logic             ps_end;
    logic             use_near;
    logic             keys_differ;
  } ctrl_sts_t;

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    absdiff8 = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [SUM_W-1:0] rgb_sum(input logic [KEY_W-1:0] p,
                                               input logic [KEY_W-1:0] c);
    rgb_sum = SUM_W'(absdiff8(p[7:0], c[7:0]))
            + SUM_W'(absdiff8(p[15:8], c[15:8]))
            + SUM_W'(absdiff8(p[23:16], c[23:16]));
  endfunction

endpackage

>>> sv/pmnc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module pmnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pmnc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences each command through the datapath.
module pmnc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  pmnc_pkg::ctrl_sts_t  sts,
  output pmnc_pkg::ctrl_cmd_t  cmd
);
  import pmnc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_MAP:  state_nxt = S_MSCAN;
          CMD_READ: state_nxt = sts.rd_in_range ? S_RDWAIT : S_DONE;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_MSCAN: begin
        if (sts.ms_hit) begin
          state_nxt = S_DONE;
        end else if (sts.ms_end) begin
          state_nxt = S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (sts.ps_exact) begin
          state_nxt = S_MINS_KEY;
        end else if (sts.ps_end) begin
          state_nxt = sts.use_near ? S_MSCAN2 : S_DONE;
        end
      end
      S_MINS_KEY: state_nxt = S_DONE;
      S_MSCAN2: begin
        if (sts.ms_hit || sts.ms_end) begin
          state_nxt = S_MINS_CHK;
        end
      end
      S_MINS_CHK: state_nxt = S_DONE;
      S_RDWAIT:   state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.in_load = in_valid;
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_CLEAR:  cmd.clear_all   = 1'b1;
          CMD_APPEND: cmd.do_append   = !sts.pal_full;
          CMD_NEWSRC: cmd.clear_memo  = 1'b1;
          CMD_MAP:    cmd.mscan_start = 1'b1;
          CMD_READ:   cmd.rd_issue    = sts.rd_in_range;
          default:    cmd = '0;
        endcase
      end
      S_MSCAN: begin
        cmd.mscan_run = 1'b1;
        if (sts.ms_hit) begin
          cmd.set_memo_hit = 1'b1;
        end else if (sts.ms_end) begin
          cmd.pscan_start = 1'b1;
        end
      end
      S_PSCAN: begin
        cmd.pscan_run = 1'b1;
        if (sts.ps_exact) begin
          cmd.set_exact = 1'b1;
        end else if (sts.ps_end) begin
          if (sts.use_near) begin
            cmd.set_nearest  = 1'b1;
            cmd.mscan_start  = 1'b1;
            cmd.key_sel_best = 1'b1;
          end else begin
            cmd.do_append = !sts.pal_full;
          end
        end
      end
      S_MINS_KEY: cmd.memo_ins = 1'b1;
      S_MSCAN2: begin
        // The nearest entry's own key goes in only when the scan missed it.
        cmd.mscan_run    = 1'b1;
        cmd.key_sel_best = 1'b1;
        cmd.memo_ins     = sts.ms_end && !sts.ms_hit;
      end
      S_MINS_CHK: cmd.memo_ins   = sts.keys_differ;
      S_RDWAIT:   cmd.rd_capture = 1'b1;
      S_DONE:     cmd.out_load   = !out_valid_r || !out_stall;
      default:    cmd = '0;
    endcase
  end

endmodule

>>> sv/pmnc_dp.sv
`timescale 1ns / 1ps
// Datapath: palette and memo memories, scan counters, compare logic and result register.
module pmnc_dp #(
  parameter int PALETTE_DEPTH = pmnc_pkg::PALETTE_DEPTH_DEF,
  parameter int MEMO_DEPTH    = pmnc_pkg::MEMO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pmnc_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pmnc_pkg::COLOR_W-1:0]  in_color,
  input  logic [pmnc_pkg::IDX_W-1:0]    in_entry_index,
  input  logic                          cfg_we,
  input  logic [pmnc_pkg::THR_W-1:0]    cfg_data,
  output logic [pmnc_pkg::IDX_W-1:0]    out_dest_index,
  output logic                          out_appended,
  output logic [pmnc_pkg::KIND_W-1:0]   out_match_kind,
  output logic [pmnc_pkg::COLOR_W-1:0]  out_entry_color,
  output logic [pmnc_pkg::PSIZE_W-1:0]  out_palette_size,
  output logic                          out_memo_full,
  input  pmnc_pkg::ctrl_cmd_t           cmd,
  output pmnc_pkg::ctrl_sts_t           sts
);
  import pmnc_pkg::*;

  localparam int PI_W = $clog2(PALETTE_DEPTH);
  localparam int PC_W = $clog2(PALETTE_DEPTH + 1);
  localparam int MA_W = $clog2(MEMO_DEPTH);
  localparam int MC_W = $clog2(MEMO_DEPTH + 1);
  localparam int ME_W = KEY_W + PI_W;

  // Item and result registers.
  logic [CMD_W-1:0]   cmd_r;
  logic [COLOR_W-1:0] color_r;
  logic [IDX_W-1:0]   eidx_r;
  logic [PI_W-1:0]    dest_r;
  logic               app_r;
  logic [KIND_W-1:0]  kind_r;
  logic [COLOR_W-1:0] ecolor_r;

  logic [THR_W-1:0]   thr_r;
  logic [PC_W-1:0]    pal_count_r;
  logic [MC_W-1:0]    memo_count_r;
  logic               dropped_r;

  // Memo scan.
  logic [MC_W-1:0]    ms_addr_r;
  logic               ms_pend_r;
  logic [KEY_W-1:0]   search_key_r;

  // Palette scan.
  logic [PC_W-1:0]    ps_addr_r;
  logic               ps_pend_r;
  logic [PI_W-1:0]    ps_didx_r;
  logic [SUM_W-1:0]   best_r;
  logic [PI_W-1:0]    best_idx_r;
  logic [KEY_W-1:0]   best_rgb_r;
  logic               found_r;

  logic [COLOR_W-1:0] pal_rdata;
  logic [PI_W-1:0]    pal_raddr;
  logic [ME_W-1:0]    memo_rdata;
  logic [ME_W-1:0]    memo_wdata;
  logic               memo_we;
  logic               memo_full_now;
  logic               pal_full;
  logic [SUM_W-1:0]   cur_sum;
  logic [KEY_W-1:0]   ins_key;

  assign pal_full      = (pal_count_r == PC_W'(PALETTE_DEPTH));
  assign memo_full_now = (memo_count_r == MC_W'(MEMO_DEPTH));
  assign pal_raddr     = cmd.rd_issue ? eidx_r[PI_W-1:0] : ps_addr_r[PI_W-1:0];
  assign cur_sum       = rgb_sum(pal_rdata[KEY_W-1:0], color_r[KEY_W-1:0]);
  assign ins_key       = cmd.key_sel_best ? best_rgb_r : color_r[KEY_W-1:0];
  assign memo_we       = cmd.memo_ins && !memo_full_now;
  assign memo_wdata    = {dest_r, ins_key};

  pmnc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (cmd.do_append),
    .waddr (pal_count_r[PI_W-1:0]),
    .wdata (color_r),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  pmnc_ram #(
    .WIDTH (ME_W),
    .DEPTH (MEMO_DEPTH)
  ) u_memo_ram (
    .clk   (clk),
    .we    (memo_we),
    .waddr (memo_count_r[MA_W-1:0]),
    .wdata (memo_wdata),
    .raddr (ms_addr_r[MA_W-1:0]),
    .rdata (memo_rdata)
  );

  always_comb begin
    sts             = '0;
    sts.cmd         = cmd_r;
    sts.pal_full    = pal_full;
    sts.rd_in_range = (PSIZE_W'(eidx_r) < PSIZE_W'(pal_count_r));
    sts.ms_hit      = ms_pend_r && (memo_rdata[KEY_W-1:0] == search_key_r);
    sts.ms_end      = !ms_pend_r && (ms_addr_r >= memo_count_r);
    sts.ps_exact    = ps_pend_r && (pal_rdata == color_r);
    sts.ps_end      = !ps_pend_r && (ps_addr_r >= pal_count_r);
    sts.use_near    = found_r && ((best_r < thr_r) || pal_full);
    sts.keys_differ = (best_rgb_r != color_r[KEY_W-1:0]);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= THR_RESET;
      pal_count_r  <= '0;
      memo_count_r <= '0;
      dropped_r    <= 1'b0;
      ms_pend_r    <= 1'b0;
      ps_pend_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
      if (cmd.clear_all) begin
        pal_count_r <= '0;
      end else if (cmd.do_append) begin
        pal_count_r <= pal_count_r + PC_W'(1);
      end
      if (cmd.clear_all || cmd.clear_memo) begin
        memo_count_r <= '0;
        dropped_r    <= 1'b0;
      end else if (cmd.memo_ins) begin
        if (memo_full_now) begin
          dropped_r <= 1'b1;
        end else begin
          memo_count_r <= memo_count_r + MC_W'(1);
        end
      end
      if (cmd.mscan_start) begin
        ms_pend_r <= 1'b0;
      end else if (cmd.mscan_run) begin
        ms_pend_r <= (ms_addr_r < memo_count_r);
      end
      if (cmd.pscan_start) begin
        ps_pend_r <= 1'b0;
      end else if (cmd.pscan_run) begin
        ps_pend_r <= (ps_addr_r < pal_count_r);
      end
    end
  end

  // Scan addresses and the running minimum.
  always_ff @(posedge clk) begin
    if (cmd.mscan_start) begin
      ms_addr_r    <= '0;
      search_key_r <= ins_key;
    end else if (cmd.mscan_run && (ms_addr_r < memo_count_r)) begin
      ms_addr_r <= ms_addr_r + MC_W'(1);
    end

    if (cmd.pscan_start) begin
      ps_addr_r <= '0;
      best_r    <= NO_DIFF;
      found_r   <= 1'b0;
    end else if (cmd.pscan_run) begin
      if (ps_addr_r < pal_count_r) begin
        ps_addr_r <= ps_addr_r + PC_W'(1);
        ps_didx_r <= ps_addr_r[PI_W-1:0];
      end
      // Strict compare keeps the lowest index on a tie.
      if (ps_pend_r && (cur_sum < best_r)) begin
        best_r     <= cur_sum;
        best_idx_r <= ps_didx_r;
        best_rgb_r <= pal_rdata[KEY_W-1:0];
        found_r    <= 1'b1;
      end
    end
  end

  // Item fields and result values.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      cmd_r    <= in_cmd;
      color_r  <= in_color;
      eidx_r   <= in_entry_index;
      dest_r   <= '0;
      app_r    <= 1'b0;
      kind_r   <= KIND_NONE;
      ecolor_r <= '0;
    end else begin
      if (cmd.do_append) begin
        dest_r <= pal_count_r[PI_W-1:0];
        app_r  <= 1'b1;
      end
      if (cmd.set_memo_hit) begin
        dest_r <= memo_rdata[KEY_W +: PI_W];
        kind_r <= KIND_MEMO;
      end
      if (cmd.set_exact) begin
        dest_r <= ps_didx_r;
        kind_r <= KIND_EXACT;
      end
      if (cmd.set_nearest) begin
        dest_r <= best_idx_r;
        kind_r <= KIND_NEAREST;
      end
      if (cmd.rd_capture) begin
        ecolor_r <= pal_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_dest_index   <= IDX_W'(dest_r);
      out_appended     <= app_r;
      out_match_kind   <= kind_r;
      out_entry_color  <= ecolor_r;
      out_palette_size <= PSIZE_W'(pal_count_r);
      out_memo_full    <= dropped_r;
    end
  end

endmodule

>>> sv/palette_merge_nearest_color.sv
`timescale 1ns / 1ps
// Top level of the palette merge block with nearest-color matching.
// Keeps a palette of up to PALETTE_DEPTH colors and a memo of up to MEMO_DEPTH
// RGB keys, and handles one command at a time, one result per command. A map
// command walks the memo and then the palette, one memory read per cycle
// through each RAM's single read port, and a nearest match sends a second memo
// search for the nearest entry's own key. A finished result sits in the output
// register while the next command is taken. The match threshold may be written
// between commands.
module palette_merge_nearest_color #(
  parameter int PALETTE_DEPTH = pmnc_pkg::PALETTE_DEPTH_DEF,
  parameter int MEMO_DEPTH    = pmnc_pkg::MEMO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pmnc_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pmnc_pkg::COLOR_W-1:0]  in_color,
  input  logic [pmnc_pkg::IDX_W-1:0]    in_entry_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pmnc_pkg::IDX_W-1:0]    out_dest_index,
  output logic                          out_appended,
  output logic [pmnc_pkg::KIND_W-1:0]   out_match_kind,
  output logic [pmnc_pkg::COLOR_W-1:0]  out_entry_color,
  output logic [pmnc_pkg::PSIZE_W-1:0]  out_palette_size,
  output logic                          out_memo_full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmnc_pkg::THR_W-1:0]    cfg_data
);
  import pmnc_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  assign cfg_ready = 1'b1;

  pmnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (ctrl_sts),
    .cmd       (ctrl_cmd)
  );

  pmnc_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MEMO_DEPTH    (MEMO_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_color         (in_color),
    .in_entry_index   (in_entry_index),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_dest_index   (out_dest_index),
    .out_appended     (out_appended),
    .out_match_kind   (out_match_kind),
    .out_entry_color  (out_entry_color),
    .out_palette_size (out_palette_size),
    .out_memo_full    (out_memo_full),
    .cmd              (ctrl_cmd),
    .sts              (ctrl_sts)
  );

`ifndef NO_ASSERTIONS
  // One command at a time: after an input transfer the block holds off the next.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a command is still in progress");

  // A new entry is always the last one of the palette.
  a_append_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_appended) |->
      ((PSIZE_W'(out_dest_index) + PSIZE_W'(1)) == out_palette_size))
    else $error("appended index does not match palette size");

  // An appended color never reports a match kind.
  a_append_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_appended) |-> (out_match_kind == KIND_NONE))
    else $error("appended result carries a match kind");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_palette_size <= PSIZE_W'(PALETTE_DEPTH)))
    else $error("palette size beyond depth");
`endif

endmodule
